// ===== src/ksd_pkg.sv =====
// ----------------------------------------------------------------------------
// ksd_pkg
// shared types, codes and scancode tables of the scancode decoder
// ----------------------------------------------------------------------------
`default_nettype none

package ksd_pkg;

  localparam int QUEUE_DEPTH_DEF = 32;
  localparam int MAX_RETRIES_DEF = 5;
  localparam int RETRY_W         = 3;
  localparam int LED_W           = 3;

  typedef enum logic [2:0] {
    KIND_CHAR     = 3'd0,
    KIND_SEND     = 3'd1,
    KIND_BREAK    = 3'd2,
    KIND_NEW_TERM = 3'd3,
    KIND_FOCUS    = 3'd4
  } kind_t;

  typedef enum logic {
    FR_IDLE,
    FR_FINISH
  } front_state_t;

  typedef struct packed {
    logic       res_valid;
    kind_t      res_kind;
    logic [7:0] res_value;
    logic       pop_valid;
    logic [7:0] pop_value;
  } rec_t;

  localparam logic [7:0] LED_CMD       = 8'hED;
  localparam logic [7:0] ACK_BYTE      = 8'hFA;
  localparam logic [7:0] RESEND_BYTE   = 8'hFE;

  localparam logic [7:0] SC_ENTER      = 8'h1C;
  localparam logic [7:0] SC_BACKSPACE  = 8'h0E;
  localparam logic [7:0] SC_TAB        = 8'h0F;
  localparam logic [7:0] SC_C_BREAK    = 8'hAE;
  localparam logic [7:0] SC_LSHIFT     = 8'h2A;
  localparam logic [7:0] SC_RSHIFT     = 8'h36;
  localparam logic [7:0] SC_LSHIFT_BRK = 8'hAA;
  localparam logic [7:0] SC_RSHIFT_BRK = 8'hB6;
  localparam logic [7:0] SC_CTRL       = 8'h1D;
  localparam logic [7:0] SC_CTRL_BRK   = 8'h9D;
  localparam logic [7:0] SC_ALT        = 8'h38;
  localparam logic [7:0] SC_ALT_BRK    = 8'hB8;
  localparam logic [7:0] SC_CAPS       = 8'h3A;
  localparam logic [7:0] SC_NUM        = 8'h45;
  localparam logic [7:0] SC_SCROLL     = 8'h46;

  localparam logic [7:0] CH_NEWLINE    = 8'd10;
  localparam logic [7:0] CH_BACKSPACE  = 8'd8;
  localparam logic [7:0] CASE_OFFSET   = 8'h20;
  localparam logic [7:0] CH_UPPER_A    = 8'h41;
  localparam logic [7:0] CH_UPPER_Z    = 8'h5A;

  function automatic logic [7:0] plain_map(input logic [6:0] code);
    logic [7:0] ch;
    case (code)
      7'h02: ch = 8'h31;
      7'h03: ch = 8'h32;
      7'h04: ch = 8'h33;
      7'h05: ch = 8'h34;
      7'h06: ch = 8'h35;
      7'h07: ch = 8'h36;
      7'h08: ch = 8'h37;
      7'h09: ch = 8'h38;
      7'h0A: ch = 8'h39;
      7'h0B: ch = 8'h30;
      7'h0C: ch = 8'h2D;
      7'h0D: ch = 8'h3D;
      7'h10: ch = 8'h51;
      7'h11: ch = 8'h57;
      7'h12: ch = 8'h45;
      7'h13: ch = 8'h52;
      7'h14: ch = 8'h54;
      7'h15: ch = 8'h59;
      7'h16: ch = 8'h55;
      7'h17: ch = 8'h49;
      7'h18: ch = 8'h4F;
      7'h19: ch = 8'h50;
      7'h1A: ch = 8'h5B;
      7'h1B: ch = 8'h5D;
      7'h1E: ch = 8'h41;
      7'h1F: ch = 8'h53;
      7'h20: ch = 8'h44;
      7'h21: ch = 8'h46;
      7'h22: ch = 8'h47;
      7'h23: ch = 8'h48;
      7'h24: ch = 8'h4A;
      7'h25: ch = 8'h4B;
      7'h26: ch = 8'h4C;
      7'h27: ch = 8'h3B;
      7'h28: ch = 8'h27;
      7'h2B: ch = 8'h5C;
      7'h2C: ch = 8'h5A;
      7'h2D: ch = 8'h58;
      7'h2E: ch = 8'h43;
      7'h2F: ch = 8'h56;
      7'h30: ch = 8'h42;
      7'h31: ch = 8'h4E;
      7'h32: ch = 8'h4D;
      7'h33: ch = 8'h2C;
      7'h34: ch = 8'h2E;
      7'h35: ch = 8'h2F;
      7'h37: ch = 8'h2A;
      7'h39: ch = 8'h20;
      7'h47: ch = 8'h37;
      7'h48: ch = 8'h38;
      7'h49: ch = 8'h39;
      7'h4A: ch = 8'h2D;
      7'h4B: ch = 8'h34;
      7'h4C: ch = 8'h35;
      7'h4D: ch = 8'h36;
      7'h4E: ch = 8'h2B;
      7'h4F: ch = 8'h31;
      7'h50: ch = 8'h32;
      7'h51: ch = 8'h33;
      7'h52: ch = 8'h30;
      7'h53: ch = 8'h2E;
      7'h73: ch = 8'h5C;
      7'h7D: ch = 8'h5C;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] shift_map(input logic [6:0] code);
    logic [7:0] ch;
    case (code)
      7'h02: ch = 8'h21;
      7'h03: ch = 8'h40;
      7'h04: ch = 8'h23;
      7'h05: ch = 8'h24;
      7'h06: ch = 8'h25;
      7'h07: ch = 8'h5E;
      7'h08: ch = 8'h26;
      7'h09: ch = 8'h2A;
      7'h0A: ch = 8'h28;
      7'h0B: ch = 8'h29;
      7'h0C: ch = 8'h5F;
      7'h0D: ch = 8'h2B;
      7'h1A: ch = 8'h7B;
      7'h1B: ch = 8'h7D;
      7'h27: ch = 8'h3A;
      7'h28: ch = 8'h22;
      7'h2B: ch = 8'h7C;
      7'h33: ch = 8'h3C;
      7'h34: ch = 8'h3E;
      7'h35: ch = 8'h3F;
      7'h73: ch = 8'h5F;
      7'h7D: ch = 8'h7C;
      default: ch = plain_map(code);
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

// ===== src/ksd_if.sv =====
// ----------------------------------------------------------------------------
// ksd channel interfaces
// valid/ready channels for keyboard bytes and decoder results
// ----------------------------------------------------------------------------
`default_nettype none

interface ksd_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] scan_byte;

  modport source (output valid, output cmd, output scan_byte, input ready);
  modport sink   (input valid, input cmd, input scan_byte, output ready);
endinterface

interface ksd_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] value;
  logic       last;

  modport source (output valid, output kind, output value, output last, input ready);
  modport sink   (input valid, input kind, input value, input last, output ready);
endinterface

`default_nettype wire

// ===== src/ksd_ram.sv =====
// ----------------------------------------------------------------------------
// ksd_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module ksd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== src/ksd_front.sv =====
// ----------------------------------------------------------------------------
// ksd_front
// accepts keyboard bytes, tracks modifier and led state, runs the command
// queue and hands the back end one record per item that has results
// ----------------------------------------------------------------------------
`default_nettype none

module ksd_front #(
  parameter int QUEUE_DEPTH = ksd_pkg::QUEUE_DEPTH_DEF,
  parameter int MAX_RETRIES = ksd_pkg::MAX_RETRIES_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic [ksd_pkg::LED_W-1:0] initial_leds,
  ksd_in_if.sink                        scan,
  input  wire logic                     rec_space,
  output logic                          rec_push,
  output ksd_pkg::rec_t                 rec
);

  localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W  = PTR_W + 1;

  ksd_pkg::front_state_t state, state_next;

  logic [1:0]                  shift_bits, shift_bits_next;
  logic                        ctrl_held, ctrl_held_next;
  logic                        alt_held, alt_held_next;
  logic [ksd_pkg::LED_W-1:0]   led_bits, led_bits_next;
  logic                        awaiting_ack, awaiting_ack_next;
  logic [7:0]                  pending_byte;
  logic [ksd_pkg::RETRY_W-1:0] retry_count, retry_count_next;
  logic [PTR_W-1:0]            queue_head, queue_head_next;
  logic [FILL_W-1:0]           queue_fill, queue_fill_next;

  // held for the second step of an item
  logic                        hold_res_valid;
  ksd_pkg::kind_t              hold_res_kind;
  logic [7:0]                  hold_res_value;
  logic                        hold_pop;
  logic                        hold_bypass;
  logic                        hold_wr_valid;
  logic [PTR_W-1:0]            hold_wr_addr;
  logic [7:0]                  hold_wr_data;

  logic                        accept;
  logic [7:0]                  lut_ch, ch;
  logic                        res_valid;
  ksd_pkg::kind_t              res_kind;
  logic [7:0]                  res_value;
  logic                        led_push;
  logic                        push1, push2;
  logic [FILL_W-1:0]           fill_mid;
  logic                        pop;
  logic [SUM_W-1:0]            tail_sum, tail2_sum;
  logic [PTR_W-1:0]            tail, tail2, head_inc;
  logic [7:0]                  pop_byte;

  logic                        ram_we;
  logic [PTR_W-1:0]            ram_waddr;
  logic [7:0]                  ram_wdata;
  logic [7:0]                  ram_rdata;

  assign accept = scan.valid && scan.ready;

  // character lookup
  always_comb begin
    lut_ch = (shift_bits != 2'b00) ? ksd_pkg::shift_map(scan.scan_byte[6:0])
                                   : ksd_pkg::plain_map(scan.scan_byte[6:0]);
    ch = scan.scan_byte[7] ? 8'h00 : lut_ch;
    if ((ch inside {[ksd_pkg::CH_UPPER_A:ksd_pkg::CH_UPPER_Z]}) &&
        (led_bits[2] == (shift_bits != 2'b00))) begin
      ch = ch + ksd_pkg::CASE_OFFSET;
    end
  end

  // byte decode and state update
  always_comb begin
    res_valid         = 1'b0;
    res_kind          = ksd_pkg::KIND_CHAR;
    res_value         = ch;
    shift_bits_next   = shift_bits;
    ctrl_held_next    = ctrl_held;
    alt_held_next     = alt_held;
    led_bits_next     = led_bits;
    awaiting_ack_next = awaiting_ack;
    retry_count_next  = retry_count;
    led_push          = 1'b0;
    if (scan.cmd) begin
      led_bits_next = initial_leds;
      led_push      = 1'b1;
    end else begin
      res_valid = (ch != 8'h00);
      case (scan.scan_byte)
        ksd_pkg::SC_ENTER: begin
          res_valid = 1'b1;
          if (alt_held && (shift_bits != 2'b00)) begin
            res_kind  = ksd_pkg::KIND_NEW_TERM;
            res_value = 8'h00;
          end else begin
            res_value = ksd_pkg::CH_NEWLINE;
          end
        end
        ksd_pkg::SC_BACKSPACE: begin
          res_valid = 1'b1;
          res_value = ksd_pkg::CH_BACKSPACE;
        end
        ksd_pkg::SC_TAB: begin
          if (alt_held) begin
            res_valid = 1'b1;
            res_kind  = ksd_pkg::KIND_FOCUS;
            res_value = 8'h00;
          end
        end
        ksd_pkg::SC_C_BREAK: begin
          if (ctrl_held) begin
            res_valid = 1'b1;
            res_kind  = ksd_pkg::KIND_BREAK;
            res_value = 8'h00;
          end
        end
        ksd_pkg::SC_LSHIFT:     shift_bits_next = shift_bits | 2'b01;
        ksd_pkg::SC_RSHIFT:     shift_bits_next = shift_bits | 2'b10;
        ksd_pkg::SC_LSHIFT_BRK: shift_bits_next = shift_bits & 2'b10;
        ksd_pkg::SC_RSHIFT_BRK: shift_bits_next = shift_bits & 2'b01;
        ksd_pkg::SC_CTRL:       ctrl_held_next = 1'b1;
        ksd_pkg::SC_CTRL_BRK:   ctrl_held_next = 1'b0;
        ksd_pkg::SC_ALT:        alt_held_next = 1'b1;
        ksd_pkg::SC_ALT_BRK:    alt_held_next = 1'b0;
        ksd_pkg::SC_CAPS: begin
          led_bits_next = led_bits ^ 3'b100;
          led_push      = 1'b1;
        end
        ksd_pkg::SC_NUM: begin
          led_bits_next = led_bits ^ 3'b010;
          led_push      = 1'b1;
        end
        ksd_pkg::SC_SCROLL: begin
          led_bits_next = led_bits ^ 3'b001;
          led_push      = 1'b1;
        end
        ksd_pkg::ACK_BYTE: begin
          awaiting_ack_next = 1'b0;
          retry_count_next  = '0;
        end
        ksd_pkg::RESEND_BYTE: begin
          if (awaiting_ack && (retry_count < ksd_pkg::RETRY_W'(MAX_RETRIES))) begin
            retry_count_next = retry_count + 1'b1;
            res_valid        = 1'b1;
            res_kind         = ksd_pkg::KIND_SEND;
            res_value        = pending_byte;
          end
        end
        default: ;
      endcase
    end
  end

  // command queue pointers
  always_comb begin
    tail_sum  = {1'b0, queue_head} + SUM_W'(queue_fill);
    tail      = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ? PTR_W'(tail_sum - SUM_W'(QUEUE_DEPTH))
                                                  : PTR_W'(tail_sum);
    tail2_sum = {1'b0, tail} + 1'b1;
    tail2     = (tail2_sum == SUM_W'(QUEUE_DEPTH)) ? '0 : PTR_W'(tail2_sum);
    head_inc  = (queue_head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : queue_head + 1'b1;

    push1    = led_push && (queue_fill < FILL_W'(QUEUE_DEPTH));
    push2    = push1 && (queue_fill < FILL_W'(QUEUE_DEPTH - 1));
    fill_mid = queue_fill + FILL_W'(push1) + FILL_W'(push2);
    pop      = !awaiting_ack_next && (fill_mid != '0);

    queue_head_next = pop ? head_inc : queue_head;
    queue_fill_next = fill_mid - FILL_W'(pop);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ksd_pkg::FR_IDLE:   if (accept) state_next = ksd_pkg::FR_FINISH;
      ksd_pkg::FR_FINISH: state_next = ksd_pkg::FR_IDLE;
      default:            state_next = ksd_pkg::FR_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    scan.ready = 1'b0;
    rec_push   = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = tail;
    ram_wdata  = ksd_pkg::LED_CMD;
    pop_byte   = hold_bypass ? ksd_pkg::LED_CMD : ram_rdata;
    rec        = '{res_valid: hold_res_valid, res_kind: hold_res_kind,
                   res_value: hold_res_value, pop_valid: hold_pop, pop_value: pop_byte};
    case (state)
      ksd_pkg::FR_IDLE: begin
        scan.ready = rec_space;
        ram_we     = accept && push1;
      end
      ksd_pkg::FR_FINISH: begin
        rec_push  = hold_res_valid || hold_pop;
        ram_we    = hold_wr_valid;
        ram_waddr = hold_wr_addr;
        ram_wdata = hold_wr_data;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ksd_pkg::FR_IDLE;
      shift_bits   <= '0;
      ctrl_held    <= 1'b0;
      alt_held     <= 1'b0;
      led_bits     <= '0;
      awaiting_ack <= 1'b0;
      pending_byte <= '0;
      retry_count  <= '0;
      queue_head   <= '0;
      queue_fill   <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        shift_bits   <= shift_bits_next;
        ctrl_held    <= ctrl_held_next;
        alt_held     <= alt_held_next;
        led_bits     <= led_bits_next;
        awaiting_ack <= awaiting_ack_next || pop;
        retry_count  <= retry_count_next;
        queue_head   <= queue_head_next;
        queue_fill   <= queue_fill_next;
      end
      if ((state == ksd_pkg::FR_FINISH) && hold_pop) begin
        pending_byte <= pop_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_res_valid <= res_valid;
      hold_res_kind  <= res_kind;
      hold_res_value <= res_value;
      hold_pop       <= pop;
      hold_bypass    <= (queue_fill == '0);
      hold_wr_valid  <= push2;
      hold_wr_addr   <= tail2;
      hold_wr_data   <= {5'b00000, led_bits_next};
    end
  end

  ksd_ram #(
    .WIDTH (8),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (queue_head),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire

// ===== src/ksd_fifo.sv =====
// ----------------------------------------------------------------------------
// ksd_fifo
// two-entry record queue between front and back end
// ----------------------------------------------------------------------------
`default_nettype none

module ksd_fifo (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire ksd_pkg::rec_t push_rec,
  output logic               space,
  input  wire logic          pop,
  output logic               empty,
  output ksd_pkg::rec_t      head_rec
);

  ksd_pkg::rec_t entries [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;

  assign space    = (count != 2'd2);
  assign empty    = (count == 2'd0);
  assign head_rec = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_rec;
    end
  end

endmodule

`default_nettype wire

// ===== src/ksd_back.sv =====
// ----------------------------------------------------------------------------
// ksd_back
// unpacks records into result items through a registered output stage
// ----------------------------------------------------------------------------
`default_nettype none

module ksd_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          empty,
  input  wire ksd_pkg::rec_t head_rec,
  output logic               pop,
  ksd_out_if.source          result
);

  logic           out_valid;
  logic [2:0]     out_kind;
  logic [7:0]     out_value;
  logic           out_last;
  logic           second;
  logic           load;
  logic           use_res;
  ksd_pkg::kind_t sel_kind;
  logic [7:0]     sel_value;
  logic           sel_last;

  assign result.valid = out_valid;
  assign result.kind  = out_kind;
  assign result.value = out_value;
  assign result.last  = out_last;

  always_comb begin
    load      = !empty && (!out_valid || result.ready);
    use_res   = !second && head_rec.res_valid;
    sel_kind  = use_res ? head_rec.res_kind : ksd_pkg::KIND_SEND;
    sel_value = use_res ? head_rec.res_value : head_rec.pop_value;
    sel_last  = !(use_res && head_rec.pop_valid);
    pop       = load && sel_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      second    <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        second    <= !sel_last;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_kind  <= sel_kind;
      out_value <= sel_value;
      out_last  <= sel_last;
    end
  end

endmodule

`default_nettype wire

// ===== src/keyboard_scancode_decoder.sv =====
// an item's first result passes the front's hold registers, the record fifo and the output
//   register; the front takes no new item while it runs its two-step sequence that shares
//   the single write port of the command queue ram between the two led command bytes
// results leave through a registered output stage at up to one per cycle while ready is high
// reset: synchronous, clears modifiers, leds, ack tracking and queue pointers;
//   queue ram contents are left as they are and no clearing pass is run
// ----------------------------------------------------------------------------
// keyboard_scancode_decoder
// set-1 scancode to character decoder with led command queue and resend handling
// ----------------------------------------------------------------------------
`default_nettype none

module keyboard_scancode_decoder #(
  parameter int QUEUE_DEPTH = ksd_pkg::QUEUE_DEPTH_DEF,
  parameter int MAX_RETRIES = ksd_pkg::MAX_RETRIES_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic [ksd_pkg::LED_W-1:0] cfg_data,
  ksd_in_if.sink                         scan,
  ksd_out_if.source                      result
);

  logic [ksd_pkg::LED_W-1:0] initial_leds;
  logic                      rec_push;
  logic                      rec_space;
  logic                      rec_pop;
  logic                      rec_empty;
  ksd_pkg::rec_t             rec_in;
  ksd_pkg::rec_t             rec_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      initial_leds <= '0;
    end else if (cfg_we) begin
      initial_leds <= cfg_data;
    end
  end

  ksd_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .MAX_RETRIES (MAX_RETRIES)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .initial_leds (initial_leds),
    .scan         (scan),
    .rec_space    (rec_space),
    .rec_push     (rec_push),
    .rec          (rec_in)
  );

  ksd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (rec_push),
    .push_rec (rec_in),
    .space    (rec_space),
    .pop      (rec_pop),
    .empty    (rec_empty),
    .head_rec (rec_head)
  );

  ksd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .empty    (rec_empty),
    .head_rec (rec_head),
    .pop      (rec_pop),
    .result   (result)
  );

endmodule

`default_nettype wire

// ===== sim/keyboard_scancode_decoder_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyboard_scancode_decoder_test
// drives set-1 keyboard bytes and start items into the decoder and checks
// each result against an in-bench decoder model: characters, events, and
// led commands with their ack and resend handling, under random idling
// ----------------------------------------------------------------------------

module keyboard_scancode_decoder_test;

  localparam int HALF_PERIOD   = 5;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 300000;
  localparam int PRINT_LIMIT   = 40;
  localparam byte NO_CHAR      = "~";

  typedef struct {
    ksd_pkg::kind_t kind;
    logic [7:0]     value;
    logic           last;
  } kb_result_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_we;
  logic [2:0] cfg_data;

  ksd_in_if  scan_ch ();
  ksd_out_if res_ch ();

  keyboard_scancode_decoder #(
    .QUEUE_DEPTH(ksd_pkg::QUEUE_DEPTH_DEF),
    .MAX_RETRIES(ksd_pkg::MAX_RETRIES_DEF)
  ) uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data),
    .scan(scan_ch),
    .result(res_ch)
  );

  // key tables indexed by make code, '~' where no character exists
  string plain_tab = {"~~1234567890-=~~", "QWERTYUIOP[]~~AS", "DFGHJKL;'~~\\ZXCV",
                      "BNM,./~*~ ~~~~~~", "~~~~~~~789-456+1", "230.~~~~~~~~~~~~",
                      "~~~~~~~~~~~~~~~~", "~~~\\~~~~~~~~~\\~~"};
  string shift_tab = {"~~!@#$%^&*()_+~~", "QWERTYUIOP{}~~AS", "DFGHJKL:\"~~|ZXCV",
                      "BNM<>?~*~ ~~~~~~", "~~~~~~~789-456+1", "230.~~~~~~~~~~~~",
                      "~~~~~~~~~~~~~~~~", "~~~_~~~~~~~~~|~~"};

  // decoder model state
  logic [1:0] shift_st    = 2'b00;
  logic       ctrl_st     = 1'b0;
  logic       alt_st      = 1'b0;
  logic [2:0] led_st      = 3'b000;
  logic [2:0] led_init    = 3'b000;
  logic       waiting_ack = 1'b0;
  logic [7:0] sent_byte   = 8'h00;
  logic [2:0] resend_cnt  = 3'd0;
  logic [7:0] led_queue[$];

  kb_result_t expected_q[$];

  int          send_idle_pct;
  int          recv_idle_pct;
  int          mismatch_count = 0;
  int unsigned cycle_count    = 0;

  always #HALF_PERIOD clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT) $display("mismatch at cycle %0d: %s", cycle_count, what);
  endtask

  function automatic void add_expected(input ksd_pkg::kind_t k, input logic [7:0] v);
    kb_result_t r;
    r.kind  = k;
    r.value = v;
    r.last  = 1'b0;
    expected_q.push_back(r);
  endfunction

  function automatic void push_led_cmd();
    if (led_queue.size() < ksd_pkg::QUEUE_DEPTH_DEF) led_queue.push_back(ksd_pkg::LED_CMD);
    if (led_queue.size() < ksd_pkg::QUEUE_DEPTH_DEF) led_queue.push_back({5'b0, led_st});
  endfunction

  function automatic void decode_item(input logic is_start, input logic [7:0] code);
    int         queued_n;
    logic [7:0] ch;
    logic       shifted;
    queued_n = expected_q.size();
    shifted  = (shift_st != 2'b00);
    if (is_start) begin
      led_st = led_init;
      push_led_cmd();
    end else begin
      ch = 8'h00;
      if (!code[7]) begin
        ch = shifted ? shift_tab[code[6:0]] : plain_tab[code[6:0]];
        if (ch == NO_CHAR) ch = 8'h00;
      end
      if (ch >= ksd_pkg::CH_UPPER_A && ch <= ksd_pkg::CH_UPPER_Z && led_st[2] == shifted)
        ch = ch + ksd_pkg::CASE_OFFSET;
      if (ch != 8'h00) add_expected(ksd_pkg::KIND_CHAR, ch);
      case (code)
        ksd_pkg::SC_ENTER: begin
          if (alt_st && shifted) add_expected(ksd_pkg::KIND_NEW_TERM, 8'h00);
          else add_expected(ksd_pkg::KIND_CHAR, ksd_pkg::CH_NEWLINE);
        end
        ksd_pkg::SC_BACKSPACE:  add_expected(ksd_pkg::KIND_CHAR, ksd_pkg::CH_BACKSPACE);
        ksd_pkg::SC_TAB:        if (alt_st) add_expected(ksd_pkg::KIND_FOCUS, 8'h00);
        ksd_pkg::SC_C_BREAK:    if (ctrl_st) add_expected(ksd_pkg::KIND_BREAK, 8'h00);
        ksd_pkg::SC_LSHIFT:     shift_st[0] = 1'b1;
        ksd_pkg::SC_RSHIFT:     shift_st[1] = 1'b1;
        ksd_pkg::SC_LSHIFT_BRK: shift_st[0] = 1'b0;
        ksd_pkg::SC_RSHIFT_BRK: shift_st[1] = 1'b0;
        ksd_pkg::SC_CTRL:       ctrl_st = 1'b1;
        ksd_pkg::SC_CTRL_BRK:   ctrl_st = 1'b0;
        ksd_pkg::SC_ALT:        alt_st = 1'b1;
        ksd_pkg::SC_ALT_BRK:    alt_st = 1'b0;
        ksd_pkg::SC_CAPS: begin
          led_st[2] = ~led_st[2];
          push_led_cmd();
        end
        ksd_pkg::SC_NUM: begin
          led_st[1] = ~led_st[1];
          push_led_cmd();
        end
        ksd_pkg::SC_SCROLL: begin
          led_st[0] = ~led_st[0];
          push_led_cmd();
        end
        ksd_pkg::ACK_BYTE: begin
          waiting_ack = 1'b0;
          resend_cnt  = 3'd0;
        end
        ksd_pkg::RESEND_BYTE: begin
          if (waiting_ack && resend_cnt < ksd_pkg::MAX_RETRIES_DEF) begin
            resend_cnt = resend_cnt + 3'd1;
            add_expected(ksd_pkg::KIND_SEND, sent_byte);
          end
        end
        default: ;
      endcase
    end
    if (!waiting_ack && led_queue.size() != 0) begin
      sent_byte   = led_queue.pop_front();
      waiting_ack = 1'b1;
      add_expected(ksd_pkg::KIND_SEND, sent_byte);
    end
    if (expected_q.size() > queued_n) expected_q[expected_q.size() - 1].last = 1'b1;
  endfunction

  // result sink with random stalls
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    kb_result_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d value %02h last %0d",
                                  res_ch.kind, res_ch.value, res_ch.last));
      end else begin
        want = expected_q.pop_front();
        if (res_ch.kind !== want.kind)
          report_mismatch($sformatf("kind %0d, want %0d", res_ch.kind, want.kind));
        if (res_ch.value !== want.value)
          report_mismatch($sformatf("value %02h, want %02h", res_ch.value, want.value));
        if (res_ch.last !== want.last)
          report_mismatch($sformatf("last %0d, want %0d", res_ch.last, want.last));
      end
    end
  end

  task automatic send_item(input logic is_start, input logic [7:0] code);
    if ($urandom_range(99) < send_idle_pct) begin
      scan_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    scan_ch.valid     <= 1'b1;
    scan_ch.cmd       <= is_start;
    scan_ch.scan_byte <= code;
    do @(posedge clk); while (!scan_ch.ready);
    decode_item(is_start, code);
  endtask

  task automatic settle();
    scan_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_leds(input logic [2:0] v);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    led_init = v;
  endtask

  function automatic logic [7:0] lock_code();
    case ($urandom_range(2))
      0:       return ksd_pkg::SC_CAPS;
      1:       return ksd_pkg::SC_NUM;
      default: return ksd_pkg::SC_SCROLL;
    endcase
  endfunction

  // start loads leds, then ack flow, resend with nothing pending, stray ack
  task automatic test_start_item();
    send_item(1'b1, 8'hFF);
    send_item(1'b0, ksd_pkg::ACK_BYTE);
    send_item(1'b0, ksd_pkg::ACK_BYTE);
    send_item(1'b0, ksd_pkg::RESEND_BYTE);
    send_item(1'b0, ksd_pkg::ACK_BYTE);
  endtask

  task automatic test_key_decoding();
    send_item(1'b0, 8'h00);
    send_item(1'b0, ksd_pkg::SC_ALT);
    send_item(1'b0, ksd_pkg::SC_LSHIFT);
    send_item(1'b0, 8'h1E);
    send_item(1'b0, 8'h7D);
    send_item(1'b0, ksd_pkg::SC_ENTER);
    send_item(1'b0, ksd_pkg::SC_TAB);
    send_item(1'b0, ksd_pkg::SC_LSHIFT_BRK);
    send_item(1'b0, ksd_pkg::SC_ALT_BRK);
    send_item(1'b0, ksd_pkg::SC_ENTER);
    send_item(1'b0, ksd_pkg::SC_BACKSPACE);
    send_item(1'b0, ksd_pkg::SC_CTRL);
    send_item(1'b0, ksd_pkg::SC_C_BREAK);
    send_item(1'b0, ksd_pkg::SC_CTRL_BRK);
  endtask

  // resends run out, then only an ack moves the queue on
  task automatic test_resend_limit();
    send_item(1'b0, ksd_pkg::SC_CAPS);
    repeat (ksd_pkg::MAX_RETRIES_DEF + 1) send_item(1'b0, ksd_pkg::RESEND_BYTE);
    send_item(1'b0, ksd_pkg::ACK_BYTE);
    send_item(1'b0, ksd_pkg::ACK_BYTE);
  endtask

  task automatic test_random_traffic(input logic [2:0] leds, input int count);
    int sent;
    int roll;
    settle();
    write_leds(leds);
    sent = 0;
    while (sent < count) begin
      roll = $urandom_range(99);
      if (roll < 3) begin
        // lock key burst without acks can fill the queue
        repeat ($urandom_range(20, 8)) begin
          send_item(1'b0, lock_code());
          sent++;
        end
      end else if (roll < 6) begin
        repeat ($urandom_range(8, 3)) begin
          send_item(1'b0, ksd_pkg::RESEND_BYTE);
          sent++;
        end
      end else if (roll < 36) begin
        send_item(1'b0, 8'($urandom_range(127)));
        sent++;
      end else if (roll < 46) begin
        case ($urandom_range(7))
          0:       send_item(1'b0, ksd_pkg::SC_LSHIFT);
          1:       send_item(1'b0, ksd_pkg::SC_RSHIFT);
          2:       send_item(1'b0, ksd_pkg::SC_LSHIFT_BRK);
          3:       send_item(1'b0, ksd_pkg::SC_RSHIFT_BRK);
          4:       send_item(1'b0, ksd_pkg::SC_CTRL);
          5:       send_item(1'b0, ksd_pkg::SC_CTRL_BRK);
          6:       send_item(1'b0, ksd_pkg::SC_ALT);
          default: send_item(1'b0, ksd_pkg::SC_ALT_BRK);
        endcase
        sent++;
      end else if (roll < 54) begin
        case ($urandom_range(3))
          0:       send_item(1'b0, ksd_pkg::SC_ENTER);
          1:       send_item(1'b0, ksd_pkg::SC_BACKSPACE);
          2:       send_item(1'b0, ksd_pkg::SC_TAB);
          default: send_item(1'b0, ksd_pkg::SC_C_BREAK);
        endcase
        sent++;
      end else if (roll < 64) begin
        send_item(1'b0, lock_code());
        sent++;
      end else if (roll < 84) begin
        send_item(1'b0, ksd_pkg::ACK_BYTE);
        sent++;
      end else if (roll < 90) begin
        send_item(1'b0, ksd_pkg::RESEND_BYTE);
        sent++;
      end else if (roll < 94) begin
        send_item(1'b1, 8'($urandom_range(255)));
        sent++;
      end else begin
        send_item(1'b0, 8'($urandom_range(255)));
        sent++;
      end
    end
  endtask

  initial begin
    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_data          = 3'd0;
    scan_ch.valid     = 1'b0;
    scan_ch.cmd       = 1'b0;
    scan_ch.scan_byte = 8'h00;
    send_idle_pct     = 21;
    recv_idle_pct     = 46;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    write_leds(3'd7);

    test_start_item();
    test_key_decoding();
    test_resend_limit();
    test_random_traffic(3'd0, 160);

    send_idle_pct = 46;
    recv_idle_pct = 21;
    test_random_traffic(3'($urandom_range(7)), 160);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(3'($urandom_range(7)), 160);

    settle();
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
